@@ rtl/pdr_pkg.sv @@
package pdr_pkg;

    // Fractional bits of the state, thrust and coefficient formats.
    localparam int FRAC_BITS = 16;

    localparam int MAX_SUBSTEPS = 64;
    localparam int CORDIC_ITERS = 30;

    // round(2^32 / (2*pi)): radians (Q.F) to a 32-bit phase
    localparam logic signed [33:0] TURN_K      = 34'sd683565276;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

    // Register indexes (word address)
    localparam logic [2:0] REG_INVERSE_MASS     = 3'd0;
    localparam logic [2:0] REG_GRAVITY          = 3'd1;
    localparam logic [2:0] REG_ARM_OVER_INERTIA = 3'd2;
    localparam logic [2:0] REG_TIME_STEP        = 3'd3;
    localparam logic [2:0] REG_SUBSTEP_COUNT    = 3'd4;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] load_pos_x;
        logic signed [31:0] load_pos_y;
        logic signed [31:0] load_tilt;
        logic signed [31:0] load_vel_x;
        logic signed [31:0] load_vel_y;
        logic signed [31:0] load_tilt_rate;
        logic signed [31:0] thrust_left;
        logic signed [31:0] thrust_right;
    } pdr_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] tilt;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] tilt_rate;
        logic               saturated;
    } pdr_out_t;

    typedef struct packed {
        logic [30:0] inverse_mass;
        logic [30:0] gravity;
        logic [30:0] arm_over_inertia;
        logic [31:0] time_step;
        logic [6:0]  substep_count;
    } pdr_cfg_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_EMIT,
        OP_SUB_INIT,
        OP_PHASE,
        OP_FOLD,
        OP_CINIT,
        OP_CITER,
        OP_TRIG,
        OP_FX,
        OP_FY,
        OP_AX,
        OP_AY,
        OP_AL,
        OP_TS_LO,
        OP_TS_HI,
        OP_TS_SUM,
        OP_DIV3,
        OP_TS_WB
    } pdr_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SUB_INIT,
        ST_PHASE,
        ST_FOLD,
        ST_CINIT,
        ST_CITER,
        ST_TRIG,
        ST_FX,
        ST_FY,
        ST_AX,
        ST_AY,
        ST_AL,
        ST_TS_LO,
        ST_TS_HI,
        ST_TS_SUM,
        ST_DIV3,
        ST_TS_WB,
        ST_EMIT
    } pdr_state_t;

    typedef struct packed {
        pdr_op_t    op;
        logic [1:0] stage;
        logic [2:0] elem;
        logic [4:0] iter;
    } pdr_cmd_t;

    typedef struct packed {
        logic is_load;
    } pdr_status_t;

endpackage

@@ rtl/pdr_datapath.sv @@
module pdr_datapath import pdr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  pdr_cmd_t    cmd,
    input  pdr_in_t     in_data,
    input  pdr_cfg_t    cfg,
    output pdr_status_t status,
    output pdr_out_t    out_data
);

    logic signed [31:0] st_reg [6];
    logic signed [31:0] st_next [6];
    logic signed [31:0] t_reg [6];
    logic signed [31:0] t_next [6];
    logic signed [31:0] kc_reg [6];
    logic signed [31:0] kc_next [6];
    logic signed [34:0] acc_reg [6];
    logic signed [34:0] acc_next [6];

    logic               flag_reg, flag_next;
    logic               is_load_reg, is_load_next;
    logic signed [32:0] tsum_reg, tsum_next;
    logic signed [32:0] tdiff_reg, tdiff_next;
    logic signed [67:0] prod_reg, prod_next;
    logic [63:0]        plo_reg, plo_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic               flip_reg, flip_next;
    logic signed [31:0] cs_reg, cs_next;
    logic signed [33:0] fx_reg, fx_next, fy_reg, fy_next;
    logic [34:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [34:0]        q_reg, q_next;
    logic [1:0]         rem_reg, rem_next;
    pdr_out_t           out_reg, out_next;

    logic signed [33:0] mul_a, mul_b;
    logic signed [32:0] ph_a;
    logic signed [33:0] fold_a;
    logic signed [33:0] dx, dy;
    logic signed [33:0] xc, yc, sn_val, cs_val;
    logic signed [67:0] shifted;
    logic signed [35:0] ts_v;
    logic [35:0]        total;
    logic [3:0]         d4;
    logic [1:0]         qd;
    logic signed [36:0] res;
    logic [32:0]        sat_r;

    function automatic logic [32:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -68'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic signed [33:0] clamp_one(input logic signed [33:0] v);
        if (v > ONE_Q30) begin
            return ONE_Q30;
        end else if (v < -ONE_Q30) begin
            return -ONE_Q30;
        end
        return v;
    endfunction

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h3243F6A8;
            5'd1:  r = 32'h1DAC6705;
            5'd2:  r = 32'h0FADBAFC;
            5'd3:  r = 32'h07F56EA6;
            5'd4:  r = 32'h03FEAB76;
            5'd5:  r = 32'h01FFD55B;
            5'd6:  r = 32'h00FFFAAA;
            5'd7:  r = 32'h007FFF55;
            5'd8:  r = 32'h003FFFEA;
            5'd9:  r = 32'h001FFFFD;
            5'd10: r = 32'h000FFFFF;
            5'd11: r = 32'h0007FFFF;
            5'd12: r = 32'h0003FFFF;
            5'd13: r = 32'h0001FFFF;
            5'd14: r = 32'h0000FFFF;
            5'd15: r = 32'h00007FFF;
            5'd16: r = 32'h00003FFF;
            5'd17: r = 32'h00001FFF;
            5'd18: r = 32'h00000FFF;
            5'd19: r = 32'h000007FF;
            5'd20: r = 32'h000003FF;
            5'd21: r = 32'h000001FF;
            5'd22: r = 32'h000000FF;
            5'd23: r = 32'h0000007F;
            5'd24: r = 32'h0000003F;
            5'd25: r = 32'h0000001F;
            5'd26: r = 32'h0000000F;
            5'd27: r = 32'h00000008;
            5'd28: r = 32'h00000004;
            5'd29: r = 32'h00000002;
            default: r = 32'h0;
        endcase
        return $signed({2'b00, r});
    endfunction

    assign status.is_load = is_load_reg;
    assign out_data       = out_reg;

    // shared signed multiplier, product registered every cycle
    assign prod_next = mul_a * mul_b;

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            st_next[j]  = st_reg[j];
            t_next[j]   = t_reg[j];
            kc_next[j]  = kc_reg[j];
            acc_next[j] = acc_reg[j];
        end
        flag_next    = flag_reg;
        is_load_next = is_load_reg;
        tsum_next    = tsum_reg;
        tdiff_next   = tdiff_reg;
        plo_next     = plo_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        flip_next    = flip_reg;
        cs_next      = cs_reg;
        fx_next      = fx_reg;
        fy_next      = fy_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        q_next       = q_reg;
        rem_next     = rem_reg;
        out_next     = out_reg;
        mul_a        = '0;
        mul_b        = '0;

        ph_a    = $signed({1'b0, prod_reg[FRAC_BITS+31:FRAC_BITS]});
        ph_a    = {ph_a[31], ph_a[31:0]};
        fold_a  = {ph_a[32], ph_a};
        dx      = y_reg >>> cmd.iter;
        dy      = x_reg >>> cmd.iter;
        xc      = clamp_one(x_reg);
        yc      = clamp_one(y_reg);
        sn_val  = flip_reg ? -yc : yc;
        cs_val  = flip_reg ? -xc : xc;
        shifted = prod_reg >>> FRAC_BITS;
        ts_v    = (cmd.stage == 2'd3)
                ? 36'(acc_reg[cmd.elem]) + 36'(kc_reg[cmd.elem])
                : 36'(kc_reg[cmd.elem]);
        total   = 36'(prod_reg[34:0]) + 36'(plo_reg[63:32]);
        d4      = {rem_reg, q_reg[33:32]};
        qd      = (d4 >= 4'd9) ? 2'd3 : (d4 >= 4'd6) ? 2'd2 : (d4 >= 4'd3) ? 2'd1 : 2'd0;
        res     = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
        sat_r   = '0;

        unique case (cmd.op)
            OP_NOP: begin
            end
            OP_LATCH: begin
                is_load_next = (in_data.command == CMD_LOAD);
                if (in_data.command == CMD_LOAD) begin
                    st_next[0] = in_data.load_pos_x;
                    st_next[1] = in_data.load_pos_y;
                    st_next[2] = in_data.load_tilt;
                    st_next[3] = in_data.load_vel_x;
                    st_next[4] = in_data.load_vel_y;
                    st_next[5] = in_data.load_tilt_rate;
                    flag_next  = 1'b0;
                end else begin
                    tsum_next  = 33'(in_data.thrust_left) + 33'(in_data.thrust_right);
                    tdiff_next = 33'(in_data.thrust_right) - 33'(in_data.thrust_left);
                end
            end
            OP_EMIT: begin
                out_next.pos_x     = st_reg[0];
                out_next.pos_y     = st_reg[1];
                out_next.tilt      = st_reg[2];
                out_next.vel_x     = st_reg[3];
                out_next.vel_y     = st_reg[4];
                out_next.tilt_rate = st_reg[5];
                out_next.saturated = flag_reg;
            end
            OP_SUB_INIT: begin
                for (int j = 0; j < 6; j++) begin
                    t_next[j]   = st_reg[j];
                    acc_next[j] = '0;
                end
            end
            OP_PHASE: begin
                mul_a = 34'(t_reg[2]);
                mul_b = TURN_K;
            end
            OP_FOLD: begin
                // fold the phase into +-quarter turn, remember the half-turn flip
                if (fold_a > 34'sh4000_0000) begin
                    fold_a    = fold_a - 34'sh8000_0000;
                    flip_next = 1'b1;
                end else if (fold_a < -34'sh4000_0000) begin
                    fold_a    = fold_a + 34'sh8000_0000;
                    flip_next = 1'b1;
                end else begin
                    flip_next = 1'b0;
                end
                mul_a = fold_a;
                mul_b = HALF_PI_Q30;
            end
            OP_CINIT: begin
                z_next = prod_reg[63:30];
                x_next = GAIN_Q30;
                y_next = '0;
            end
            OP_CITER: begin
                if (z_reg >= 0) begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_q30(cmd.iter);
                end else begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_q30(cmd.iter);
                end
            end
            OP_TRIG: begin
                cs_next = cs_val[31:0];
                mul_a   = 34'(tsum_reg);
                mul_b   = sn_val;
            end
            OP_FX: begin
                fx_next = prod_reg[63:30];
                mul_a   = 34'(tsum_reg);
                mul_b   = 34'(cs_reg);
            end
            OP_FY: begin
                fy_next = prod_reg[63:30];
                mul_a   = fx_reg;
                mul_b   = $signed({3'b000, cfg.inverse_mass});
            end
            OP_AX: begin
                sat_r      = sat32(-shifted);
                kc_next[3] = sat_r[31:0];
                flag_next  = flag_reg | sat_r[32];
                mul_a      = fy_reg;
                mul_b      = $signed({3'b000, cfg.inverse_mass});
            end
            OP_AY: begin
                sat_r      = sat32(shifted - $signed({37'b0, cfg.gravity}));
                kc_next[4] = sat_r[31:0];
                flag_next  = flag_reg | sat_r[32];
                mul_a      = 34'(tdiff_reg);
                mul_b      = $signed({3'b000, cfg.arm_over_inertia});
            end
            OP_AL: begin
                sat_r      = sat32(shifted);
                kc_next[5] = sat_r[31:0];
                flag_next  = flag_reg | sat_r[32];
                kc_next[0] = t_reg[3];
                kc_next[1] = t_reg[4];
                kc_next[2] = t_reg[5];
            end
            OP_TS_LO: begin
                if (cmd.stage == 2'd1 || cmd.stage == 2'd2) begin
                    acc_next[cmd.elem] = acc_reg[cmd.elem] + 35'(kc_reg[cmd.elem] * 2);
                end else begin
                    acc_next[cmd.elem] = acc_reg[cmd.elem] + 35'(kc_reg[cmd.elem]);
                end
                neg_next = ts_v[35];
                mag_next = ts_v[35] ? 35'(-ts_v) : 35'(ts_v);
                mul_a    = ts_v[35] ? $signed({2'b00, 32'(-ts_v)}) : $signed({2'b00, ts_v[31:0]});
                mul_b    = $signed({2'b00, cfg.time_step});
            end
            OP_TS_HI: begin
                plo_next = prod_reg[63:0];
                mul_a    = $signed({31'b0, mag_reg[34:32]});
                mul_b    = $signed({2'b00, cfg.time_step});
            end
            OP_TS_SUM: begin
                // floor(|v| * h / 2^32), then the halving where it applies
                q_next   = (cmd.stage == 2'd2) ? total[34:0] : total[35:1];
                rem_next = '0;
            end
            OP_DIV3: begin
                // radix-4 long division by three, top digit first
                rem_next = 2'(d4 - 4'(qd) * 4'd3);
                q_next   = {1'b0, q_reg[31:0], qd};
            end
            OP_TS_WB: begin
                sat_r     = sat32(68'(st_reg[cmd.elem]) + 68'(res));
                flag_next = flag_reg | sat_r[32];
                if (cmd.stage == 2'd3) begin
                    st_next[cmd.elem] = sat_r[31:0];
                end else begin
                    t_next[cmd.elem] = sat_r[31:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 6; j++) begin
                st_reg[j] <= '0;
            end
            flag_reg    <= 1'b0;
            is_load_reg <= 1'b0;
        end else begin
            for (int j = 0; j < 6; j++) begin
                st_reg[j] <= st_next[j];
            end
            flag_reg    <= flag_next;
            is_load_reg <= is_load_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < 6; j++) begin
            t_reg[j]   <= t_next[j];
            kc_reg[j]  <= kc_next[j];
            acc_reg[j] <= acc_next[j];
        end
        tsum_reg  <= tsum_next;
        tdiff_reg <= tdiff_next;
        prod_reg  <= prod_next;
        plo_reg   <= plo_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        flip_reg  <= flip_next;
        cs_reg    <= cs_next;
        fx_reg    <= fx_next;
        fy_reg    <= fy_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        q_reg     <= q_next;
        rem_reg   <= rem_next;
        out_reg   <= out_next;
    end

endmodule

@@ rtl/pdr_controller.sv @@
module pdr_controller import pdr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  logic [6:0]  substep_count,
    input  pdr_status_t status,
    output pdr_cmd_t    cmd
);

    pdr_state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] elem_reg, elem_next;
    logic [1:0] stage_reg, stage_next;
    logic [6:0] sub_reg, sub_next;
    logic       m_valid_reg, m_valid_next;
    logic [6:0] n_sub;
    logic       out_free;

    assign n_sub    = (substep_count > 7'(MAX_SUBSTEPS)) ? 7'(MAX_SUBSTEPS) : substep_count;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        elem_next  = elem_reg;
        stage_next = stage_reg;
        sub_next   = sub_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                sub_next = '0;
                if (status.is_load || n_sub == 7'd0) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_SUB_INIT;
                end
            end
            ST_SUB_INIT: begin
                stage_next = '0;
                state_next = ST_PHASE;
            end
            ST_PHASE: state_next = ST_FOLD;
            ST_FOLD:  state_next = ST_CINIT;
            ST_CINIT: begin
                cnt_next   = '0;
                state_next = ST_CITER;
            end
            ST_CITER: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_ITERS - 1)) begin
                    state_next = ST_TRIG;
                end
            end
            ST_TRIG: state_next = ST_FX;
            ST_FX:   state_next = ST_FY;
            ST_FY:   state_next = ST_AX;
            ST_AX:   state_next = ST_AY;
            ST_AY:   state_next = ST_AL;
            ST_AL: begin
                elem_next  = '0;
                state_next = ST_TS_LO;
            end
            ST_TS_LO: state_next = ST_TS_HI;
            ST_TS_HI: state_next = ST_TS_SUM;
            ST_TS_SUM: begin
                cnt_next   = '0;
                state_next = (stage_reg == 2'd3) ? ST_DIV3 : ST_TS_WB;
            end
            ST_DIV3: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16) begin
                    state_next = ST_TS_WB;
                end
            end
            ST_TS_WB: begin
                if (elem_reg == 3'd5) begin
                    if (stage_reg == 2'd3) begin
                        sub_next   = sub_reg + 7'd1;
                        state_next = (sub_reg == n_sub - 7'd1) ? ST_EMIT : ST_SUB_INIT;
                    end else begin
                        stage_next = stage_reg + 2'd1;
                        state_next = ST_PHASE;
                    end
                end else begin
                    elem_next  = elem_reg + 3'd1;
                    state_next = ST_TS_LO;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.stage    = stage_reg;
        cmd.elem     = elem_reg;
        cmd.iter     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE:     cmd.op = s_valid ? OP_LATCH : OP_NOP;
            ST_DISPATCH: cmd.op = OP_NOP;
            ST_SUB_INIT: cmd.op = OP_SUB_INIT;
            ST_PHASE:    cmd.op = OP_PHASE;
            ST_FOLD:     cmd.op = OP_FOLD;
            ST_CINIT:    cmd.op = OP_CINIT;
            ST_CITER:    cmd.op = OP_CITER;
            ST_TRIG:     cmd.op = OP_TRIG;
            ST_FX:       cmd.op = OP_FX;
            ST_FY:       cmd.op = OP_FY;
            ST_AX:       cmd.op = OP_AX;
            ST_AY:       cmd.op = OP_AY;
            ST_AL:       cmd.op = OP_AL;
            ST_TS_LO:    cmd.op = OP_TS_LO;
            ST_TS_HI:    cmd.op = OP_TS_HI;
            ST_TS_SUM:   cmd.op = OP_TS_SUM;
            ST_DIV3:     cmd.op = OP_DIV3;
            ST_TS_WB:    cmd.op = OP_TS_WB;
            ST_EMIT: begin
                cmd.op = out_free ? OP_EMIT : OP_NOP;
                if (out_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default:     cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            elem_reg    <= '0;
            stage_reg   <= '0;
            sub_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            elem_reg    <= elem_next;
            stage_reg   <= stage_next;
            sub_reg     <= sub_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ rtl/planar_drone_rk4_stepper_core.sv @@
// Planar two-rotor drone plant model. Holds x, y, tilt and their rates in
// Q16.16. A load request replaces the state and clears the saturation flag;
// an advance request runs substep_count (capped at 64) classic RK4 substeps
// of length time_step with the given thrusts. Every request returns one
// result: the state after it plus the sticky saturation flag.
// A load goes from acceptance through a dispatch state to the emit state,
// which fills the output register and raises m_valid; an advance runs its
// substeps (20 at reset) between dispatch and emit. Either may also wait
// for the output register to free up. Each substep is one setup state, four
// derivative evaluations (dominated by the CORDIC loop), and 24 time-scale
// updates on one shared 34x34 multiplier, the final six also paying a
// 17-step divide by three. One request is in work at a time; a finished
// result waits in the output register while the next request is accepted.
// Registers (APB, 4-byte stride): 0 inverse_mass, 1 gravity,
// 2 arm_over_inertia, 3 time_step, 4 substep_count. Write them only idle.
module planar_drone_rk4_stepper_core import pdr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  pdr_in_t     s_data,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output pdr_out_t    m_data,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pdr_cfg_t    cfg_reg, cfg_next;
    pdr_cmd_t    cmd;
    pdr_status_t status;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[4:2])
                REG_INVERSE_MASS:     cfg_next.inverse_mass     = pwdata[30:0];
                REG_GRAVITY:          cfg_next.gravity          = pwdata[30:0];
                REG_ARM_OVER_INERTIA: cfg_next.arm_over_inertia = pwdata[30:0];
                REG_TIME_STEP:        cfg_next.time_step        = pwdata;
                REG_SUBSTEP_COUNT:    cfg_next.substep_count    = pwdata[6:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[4:2])
            REG_INVERSE_MASS:     prdata = {1'b0, cfg_reg.inverse_mass};
            REG_GRAVITY:          prdata = {1'b0, cfg_reg.gravity};
            REG_ARM_OVER_INERTIA: prdata = {1'b0, cfg_reg.arm_over_inertia};
            REG_TIME_STEP:        prdata = cfg_reg.time_step;
            REG_SUBSTEP_COUNT:    prdata = {25'b0, cfg_reg.substep_count};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inverse_mass     <= 31'd43691;
            cfg_reg.gravity          <= 31'd642908;
            cfg_reg.arm_over_inertia <= 31'd131072;
            cfg_reg.time_step        <= 32'd4294967;
            cfg_reg.substep_count    <= 7'd20;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencer: walks the substep / stage / element schedule
    pdr_controller u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .substep_count (cfg_reg.substep_count),
        .status        (status),
        .cmd           (cmd)
    );

    // state, CORDIC, shared multiplier, time scaling, output register
    pdr_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_data  (s_data),
        .cfg      (cfg_reg),
        .status   (status),
        .out_data (m_data)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import pdr_pkg::*;

    typedef longint vec6_t [0:5];

    // ---------------------------------------------------------------
    // Clock, reset and the signals around the block
    // ---------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    pdr_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    pdr_out_t    m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    planar_drone_rk4_stepper_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ---------------------------------------------------------------
    // Plant predictor: own copy of the registers and the drone state
    // ---------------------------------------------------------------
    longint unsigned mass_inv_q = 43691;
    longint unsigned grav_q     = 642908;
    longint unsigned arm_q      = 131072;
    longint unsigned step_h     = 4294967;
    longint unsigned n_sub      = 20;
    vec6_t           plant      = '{0, 0, 0, 0, 0, 0};
    bit              plant_sat  = 1'b0;

    longint atan_tab [0:29] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
    };

    // clamp to 32 bits; any clamp raises the sticky flag
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            plant_sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            plant_sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint clamp_unit(longint v);
        longint one;
        one = longint'(ONE_Q30);
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

    // tilt -> 32-bit phase, fold to +-pi/2, 30-step CORDIC (Q2.30 out)
    task automatic tilt_trig(input longint theta, output longint sn, output longint cs);
        longint      prod, a, z, x, y, dx, dy;
        logic [31:0] ph;
        bit          flip;
        prod = theta * longint'(TURN_K);
        ph   = prod[47:16];
        a    = longint'($signed(ph));
        flip = 1'b0;
        if (a > 64'sh40000000) begin
            a = a - 64'sh80000000;
            flip = 1'b1;
        end else if (a < -64'sh40000000) begin
            a = a + 64'sh80000000;
            flip = 1'b1;
        end
        z = (a * longint'(HALF_PI_Q30)) >>> 30;
        x = longint'(GAIN_Q30);
        y = 0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_tab[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_tab[i];
            end
        end
        x  = clamp_unit(x);
        y  = clamp_unit(y);
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    // sign(v) * floor(|v| * h / (div * 2^32)), truncated toward zero
    function automatic longint step_scaled(longint v, longint unsigned div);
        longint unsigned mag, hi, lo, q;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        hi  = (mag >> 16) * step_h;
        lo  = (mag & 64'hFFFF) * step_h;
        q   = ((hi + (lo >> 16)) >> 16) / div;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    task automatic plant_rates(input vec6_t s, input longint tsum, input longint tdiff,
                               output vec6_t k);
        longint sn, cs, fx, fy;
        k[0] = s[3];
        k[1] = s[4];
        k[2] = s[5];
        tilt_trig(s[2], sn, cs);
        fx   = (tsum * sn) >>> 30;
        fy   = (tsum * cs) >>> 30;
        k[3] = clamp32(-((fx * longint'(mass_inv_q)) >>> FRAC_BITS));
        k[4] = clamp32(((fy * longint'(mass_inv_q)) >>> FRAC_BITS) - longint'(grav_q));
        k[5] = clamp32((tdiff * longint'(arm_q)) >>> FRAC_BITS);
    endtask

    task automatic rk4_advance(input longint tsum, input longint tdiff);
        vec6_t  k1, k2, k3, k4, mid;
        longint acc;
        plant_rates(plant, tsum, tdiff, k1);
        for (int j = 0; j < 6; j++) mid[j] = clamp32(plant[j] + step_scaled(k1[j], 2));
        plant_rates(mid, tsum, tdiff, k2);
        for (int j = 0; j < 6; j++) mid[j] = clamp32(plant[j] + step_scaled(k2[j], 2));
        plant_rates(mid, tsum, tdiff, k3);
        for (int j = 0; j < 6; j++) mid[j] = clamp32(plant[j] + step_scaled(k3[j], 1));
        plant_rates(mid, tsum, tdiff, k4);
        for (int j = 0; j < 6; j++) begin
            acc      = k1[j] + 2 * k2[j] + 2 * k3[j] + k4[j];
            plant[j] = clamp32(plant[j] + step_scaled(acc, 6));
        end
    endtask

    task automatic plant_apply(input pdr_in_t rq, output pdr_out_t rs);
        longint tl, tr;
        longint unsigned n;
        if (rq.command == CMD_LOAD) begin
            plant[0]  = longint'(rq.load_pos_x);
            plant[1]  = longint'(rq.load_pos_y);
            plant[2]  = longint'(rq.load_tilt);
            plant[3]  = longint'(rq.load_vel_x);
            plant[4]  = longint'(rq.load_vel_y);
            plant[5]  = longint'(rq.load_tilt_rate);
            plant_sat = 1'b0;
        end else begin
            tl = longint'(rq.thrust_left);
            tr = longint'(rq.thrust_right);
            n  = (n_sub > MAX_SUBSTEPS) ? MAX_SUBSTEPS : n_sub;
            for (longint unsigned i = 0; i < n; i++) rk4_advance(tl + tr, tr - tl);
        end
        rs.pos_x     = plant[0][31:0];
        rs.pos_y     = plant[1][31:0];
        rs.tilt      = plant[2][31:0];
        rs.vel_x     = plant[3][31:0];
        rs.vel_y     = plant[4][31:0];
        rs.tilt_rate = plant[5][31:0];
        rs.saturated = plant_sat;
    endtask

    // ---------------------------------------------------------------
    // Request driver: pops pending requests, random gaps, changes at negedge
    // ---------------------------------------------------------------
    pdr_in_t  pending_q [$];
    pdr_out_t expected_states [$];
    int       n_queued   = 0;
    int       n_accepted = 0;
    bit       calm       = 1'b0;   // no idling on either side
    bit       req_taken  = 1'b0;
    int       req_gap    = 0;
    int       rsp_stall  = 0;
    bit       failed     = 1'b0;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(3, 40);
    endfunction

    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && !req_taken) begin
                // hold the request until it is accepted
            end else if (req_gap > 0) begin
                s_valid <= 1'b0;
                req_gap <= req_gap - 1;
            end else if (pending_q.size() > 0) begin
                s_data  <= pending_q.pop_front();
                s_valid <= 1'b1;
                req_gap <= calm ? 0 : (($urandom_range(0, 2) == 0) ? gap_len() : 0);
            end else begin
                s_valid <= 1'b0;
            end
            req_taken = 1'b0;
        end
    end

    // accepted request -> prediction
    always @(posedge aclk) begin
        pdr_out_t rs;
        if (aresetn && s_valid && s_ready) begin
            req_taken = 1'b1;
            plant_apply(s_data, rs);
            expected_states = {expected_states, rs};
            n_accepted++;
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: random back-pressure, compare at posedge
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn) begin
            if (rsp_stall > 0) begin
                m_ready   <= 1'b0;
                rsp_stall <= rsp_stall - 1;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) rsp_stall <= gap_len();
            end
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        pdr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_states.size() == 0) begin
                $error("result with no request outstanding");
                failed = 1'b1;
            end else begin
                want = expected_states.pop_front();
                check_field("pos_x", want.pos_x, m_data.pos_x);
                check_field("pos_y", want.pos_y, m_data.pos_y);
                check_field("tilt", want.tilt, m_data.tilt);
                check_field("vel_x", want.vel_x, m_data.vel_x);
                check_field("vel_y", want.vel_y, m_data.vel_y);
                check_field("tilt_rate", want.tilt_rate, m_data.tilt_rate);
                check_field("saturated", want.saturated, m_data.saturated);
            end
        end
    end

    // ---------------------------------------------------------------
    // Configuration writes (only while the block is idle)
    // ---------------------------------------------------------------
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        // mirror the write into the predictor, masked to register width
        case (idx)
            REG_INVERSE_MASS:     mass_inv_q = value & 32'h7FFF_FFFF;
            REG_GRAVITY:          grav_q     = value & 32'h7FFF_FFFF;
            REG_ARM_OVER_INERTIA: arm_q      = value & 32'h7FFF_FFFF;
            REG_TIME_STEP:        step_h     = value;
            REG_SUBSTEP_COUNT:    n_sub      = value & 32'h7F;
            default: ;
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_plant_regs(input logic [31:0] im, input logic [31:0] g,
                                  input logic [31:0] arm, input logic [31:0] h,
                                  input logic [31:0] n);
        apb_write(REG_INVERSE_MASS, im);
        apb_write(REG_GRAVITY, g);
        apb_write(REG_ARM_OVER_INERTIA, arm);
        apb_write(REG_TIME_STEP, h);
        apb_write(REG_SUBSTEP_COUNT, n);
    endtask

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic send(input pdr_in_t rq);
        pending_q = {pending_q, rq};
        n_queued++;
    endtask

    // sender holds off until every request is answered
    task automatic drain();
        wait (n_accepted == n_queued && expected_states.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            default: begin
                logic [31:0] m;
                m = $urandom & ((32'd1 << $urandom_range(8, 22)) - 1);
                return $urandom_range(0, 1) ? -m : m;
            end
        endcase
    endfunction

    function automatic pdr_in_t make_req(input logic cmd);
        pdr_in_t rq;
        rq.command        = cmd;
        rq.load_pos_x     = pick_q16();
        rq.load_pos_y     = pick_q16();
        rq.load_tilt      = pick_q16();
        rq.load_vel_x     = pick_q16();
        rq.load_vel_y     = pick_q16();
        rq.load_tilt_rate = pick_q16();
        rq.thrust_left    = pick_q16();
        rq.thrust_right   = pick_q16();
        // near hover thrust now and then
        if ($urandom_range(0, 3) == 0) begin
            rq.thrust_left  = 32'sd482000 + $signed($urandom_range(0, 40000)) - 32'sd20000;
            rq.thrust_right = 32'sd482000 + $signed($urandom_range(0, 40000)) - 32'sd20000;
        end
        return rq;
    endfunction

    // mostly load-then-advance sequences, the rest random noise
    task automatic random_phase(input int n);
        int cnt;
        int runs;
        cnt = 0;
        while (cnt < n) begin
            if ($urandom_range(0, 9) < 8) begin
                send(make_req(CMD_LOAD));
                runs = $urandom_range(1, 4);
                for (int i = 0; i < runs; i++) send(make_req(CMD_ADVANCE));
                cnt += runs + 1;
            end else begin
                send(make_req($urandom_range(0, 1)));
                cnt++;
            end
        end
        drain();
    endtask

    function automatic pdr_in_t state_req(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] th, input logic [31:0] vx,
                                          input logic [31:0] vy, input logic [31:0] w);
        pdr_in_t rq;
        rq = '0;
        rq.command        = CMD_LOAD;
        rq.load_pos_x     = x;
        rq.load_pos_y     = y;
        rq.load_tilt      = th;
        rq.load_vel_x     = vx;
        rq.load_vel_y     = vy;
        rq.load_tilt_rate = w;
        return rq;
    endfunction

    function automatic pdr_in_t thrust_req(input logic [31:0] tl, input logic [31:0] tr);
        pdr_in_t rq;
        rq = '0;
        rq.command      = CMD_ADVANCE;
        rq.thrust_left  = tl;
        rq.thrust_right = tr;
        return rq;
    endfunction

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        pdr_in_t rq;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        // Directed part at reset register values (20 substeps).
        calm = 1'b1;
        send(thrust_req(32'sd482000, 32'sd482000));           // from reset state
        send(state_req(0, 0, 0, 0, 0, 0));
        send(thrust_req(32'sd482000, 32'sd490000));           // hover, slight roll
        send(state_req(0, 0, 32'h0001_921F, 0, 0, 0));       // tilt pi/2
        send(thrust_req(32'sd600000, 32'sd600000));
        send(state_req(0, 0, 32'h0003_243F, 0, 0, 0));       // tilt pi, fold case
        send(thrust_req(32'sd600000, 32'sd600000));
        send(state_req(0, 0, 32'h7FFF_FFFF, 0, 0, 0));       // tilt many turns
        send(thrust_req(32'h7FFF_FFFF, 32'h7FFF_FFFF));       // thrust extremes
        send(state_req(0, 0, 32'h8000_0000, 0, 0, 0));
        send(thrust_req(32'h8000_0000, 32'h8000_0000));
        // state near the top of range: positions clamp, sticky flag set
        send(state_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send(thrust_req(32'h8000_0000, 32'h7FFF_FFFF));
        send(thrust_req(0, 0));                               // flag stays set
        rq = state_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000);
        rq.thrust_left  = 32'h7FFF_FFFF;                      // ignored by a load
        rq.thrust_right = 32'h8000_0000;
        send(rq);
        rq = thrust_req(32'h7FFF_FFFF, 32'h8000_0000);
        rq.load_pos_x = 32'h1234_5678;                        // ignored by an advance
        send(rq);
        send(state_req(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000, 0, 0, 0));
        send(thrust_req(32'hFFFF_FFFF, 32'h0000_0001));
        drain();
        calm = 1'b0;

        // Random phases over several register settings.
        set_plant_regs(32'd43691, 32'd642908, 32'd131072, 32'd4294967, 32'd1);
        random_phase(60);
        set_plant_regs(32'd1, 32'd0, 32'd0, 32'd1, 32'd2);        // low extremes
        random_phase(40);
        // high extremes; write all ones to check width masking
        set_plant_regs(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        random_phase(40);
        calm = 1'b1;
        set_plant_regs(32'd43691, 32'd642908, 32'd131072, 32'd4294967, 32'd0); // no substeps
        random_phase(20);
        calm = 1'b0;
        apb_write(REG_SUBSTEP_COUNT, 32'd127);                // capped at 64 substeps
        random_phase(6);
        set_plant_regs(32'd43691, 32'd642908, 32'd131072, 32'hFFFF_FFFF, 32'd64);
        random_phase(4);
        set_plant_regs($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 3));
        random_phase(60);
        apb_write(3'd5, 32'hFFFF_FFFF);                       // unmapped, ignored
        set_plant_regs(32'd65536, 32'd642908, $urandom, 32'd42949673, 32'd3);
        random_phase(60);

        drain();
        if (!failed) begin
            $display("PASS planar_drone_rk4_stepper_core");
        end else begin
            $display("FAIL planar_drone_rk4_stepper_core");
        end
        $finish;
    end

    // Run limit, well past the slowest correct run.
    initial begin
        #40_000_000;
        $display("FAIL planar_drone_rk4_stepper_core");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/pdr_pkg.sv
rtl/pdr_datapath.sv
rtl/pdr_controller.sv
rtl/planar_drone_rk4_stepper_core.sv
tb/tb.sv
